// ===== src/fkrs_pkg.sv =====
// ----------------------------------------------------------------------------
// fkrs_pkg
// shared types, constants and helpers for the float key radix sorter
// ----------------------------------------------------------------------------
package fkrs_pkg;

  localparam int KEY_W       = 32;
  localparam int BIT_W       = 5;
  localparam int STACK_DEPTH = 32;
  localparam int STK_IDX_W   = 5;
  localparam int SP_W        = 6;

  localparam logic [BIT_W-1:0] SIGN_BIT = 5'd31;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_RD_L,
    ST_CHK_L,
    ST_RD_R,
    ST_CHK_R,
    ST_SWAP,
    ST_PUSH_HI,
    ST_PUSH_LO,
    ST_POP,
    ST_LOAD,
    ST_EMIT
  } fkrs_state_t;

  // key belongs in the lower part of the range for this direction
  function automatic logic goes_low(input logic dir, input logic [KEY_W-1:0] x,
                                    input logic [BIT_W-1:0] bitn);
    return dir == ~x[bitn];
  endfunction

endpackage

// ===== src/float_key_msb_radix_sorter.sv =====
// ----------------------------------------------------------------------------
// float_key_msb_radix_sorter
// loads ieee single-precision keys and emits them sorted by an msb-first
// binary radix partition driven by an explicit range stack
// ----------------------------------------------------------------------------
//
//  channel   ports                                            handshake
//  -------   -----------------------------------------------  -------------------
//  input     in_key, in_last_key                              start & !busy
//  result    out_sorted_key, out_last_out, out_overflowed     out_valid strobe
//  config    cfg_sort_ascending                               cfg_we
//
//  a key is taken on each accepted start; a key without in_last_key gives no result
//  the final key starts the sort: every partition pass walks its range with
//  one key-store read port and one write port, reading and checking each key
//  and swapping misplaced pairs, over up to 32 bit levels
//  results then leave one per cycle from the registered read port
//  reset only clears control state; the key store needs no clearing pass
//  the receiver cannot stall, so busy is the only back-pressure
//
module float_key_msb_radix_sorter
  import fkrs_pkg::*;
#(
  parameter int MAX_KEYS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  // input transaction
  input  logic             start,
  output logic             busy,
  input  logic [KEY_W-1:0] in_key,
  input  logic             in_last_key,
  // configuration
  input  logic             cfg_we,
  input  logic             cfg_sort_ascending,
  // result transaction
  output logic             out_valid,
  output logic [KEY_W-1:0] out_sorted_key,
  output logic             out_last_out,
  output logic             out_overflowed
);

  localparam int IDX_W = (MAX_KEYS > 2) ? $clog2(MAX_KEYS) : 1;
  localparam int CNT_W = $clog2(MAX_KEYS + 1);

  // control and sequencing state
  fkrs_state_t      state_r, state_nxt;
  logic             asc_r, asc_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;

  // current partition job
  logic [IDX_W-1:0] left_r, left_nxt;
  logic [IDX_W-1:0] right_r, right_nxt;
  logic [BIT_W-1:0] bitn_r, bitn_nxt;
  logic             dir_r, dir_nxt;
  logic             is_top_r, is_top_nxt;
  logic [CNT_W-1:0] l_r, l_nxt;       // scan from the left
  logic [CNT_W-1:0] rend_r, rend_nxt; // one past the right scan position
  logic [KEY_W-1:0] lkey_r, lkey_nxt; // key held for a swap
  logic [SP_W-1:0]  sp_r, sp_nxt;

  // result stage
  logic             emit_v_r, emit_v_nxt;
  logic             emit_last_r, emit_last_nxt;
  logic             emit_ovf_r, emit_ovf_nxt;

  // key store ports
  logic [KEY_W-1:0] key_mem [MAX_KEYS];
  logic [IDX_W-1:0] mem_raddr;
  logic [KEY_W-1:0] mem_rdata_r;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [KEY_W-1:0] mem_wdata;

  // range stack
  logic [IDX_W-1:0] stk_left  [STACK_DEPTH];
  logic [IDX_W-1:0] stk_right [STACK_DEPTH];
  logic [BIT_W-1:0] stk_bitn  [STACK_DEPTH];
  logic             stk_dir   [STACK_DEPTH];
  logic             stk_we;
  logic [IDX_W-1:0] stk_wleft, stk_wright;
  logic [BIT_W-1:0] stk_wbitn;
  logic             stk_wdir;
  logic [STK_IDX_W-1:0] stk_top;
  logic [IDX_W-1:0] stk_rd_left_r, stk_rd_right_r;
  logic [BIT_W-1:0] stk_rd_bitn_r;
  logic             stk_rd_dir_r;

  logic accept;
  logic more_levels;
  logic push_ok;
  logic key_low;

  assign accept      = start && (state_r == ST_IDLE);
  assign busy        = (state_r != ST_IDLE);
  assign stk_top     = STK_IDX_W'(sp_r - SP_W'(1));
  assign more_levels = is_top_r || (bitn_r != '0);
  assign push_ok     = more_levels && (sp_r < SP_W'(STACK_DEPTH));
  assign key_low     = goes_low(dir_r, mem_rdata_r, bitn_r);

  assign out_valid      = emit_v_r;
  assign out_sorted_key = mem_rdata_r;
  assign out_last_out   = emit_last_r;
  assign out_overflowed = emit_ovf_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_last_key) state_nxt = ST_START;
      end
      ST_START: begin
        state_nxt = (count_r > CNT_W'(1)) ? ST_RD_L : ST_EMIT;
      end
      ST_RD_L: begin
        state_nxt = (l_r < rend_r) ? ST_CHK_L : ST_PUSH_HI;
      end
      ST_CHK_L: begin
        state_nxt = key_low ? ST_RD_L : ST_RD_R;
      end
      ST_RD_R: begin
        state_nxt = (l_r < rend_r) ? ST_CHK_R : ST_PUSH_HI;
      end
      ST_CHK_R: begin
        state_nxt = key_low ? ST_SWAP : ST_RD_R;
      end
      ST_SWAP:    state_nxt = ST_RD_L;
      ST_PUSH_HI: state_nxt = ST_PUSH_LO;
      ST_PUSH_LO: state_nxt = ST_POP;
      ST_POP: begin
        state_nxt = (sp_r == '0) ? ST_EMIT : ST_LOAD;
      end
      ST_LOAD:    state_nxt = ST_RD_L;
      ST_EMIT: begin
        if (l_r + CNT_W'(1) == count_r) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and port controls
  always_comb begin
    asc_nxt       = cfg_we ? cfg_sort_ascending : asc_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    bitn_nxt      = bitn_r;
    dir_nxt       = dir_r;
    is_top_nxt    = is_top_r;
    l_nxt         = l_r;
    rend_nxt      = rend_r;
    lkey_nxt      = lkey_r;
    sp_nxt        = sp_r;
    emit_v_nxt    = 1'b0;
    emit_last_nxt = 1'b0;
    emit_ovf_nxt  = emit_ovf_r;
    mem_raddr     = l_r[IDX_W-1:0];
    mem_we        = 1'b0;
    mem_waddr     = l_r[IDX_W-1:0];
    mem_wdata     = mem_rdata_r;
    stk_we        = 1'b0;
    stk_wleft     = left_r;
    stk_wright    = right_r;
    stk_wbitn     = bitn_r - BIT_W'(1);
    stk_wdir      = dir_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (count_r < CNT_W'(MAX_KEYS)) begin
            mem_we    = 1'b1;
            mem_waddr = count_r[IDX_W-1:0];
            mem_wdata = in_key;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      ST_START: begin
        // sign level first, in the reverse of the requested direction
        left_nxt   = '0;
        right_nxt  = IDX_W'(count_r - CNT_W'(1));
        bitn_nxt   = SIGN_BIT;
        dir_nxt    = ~asc_r;
        is_top_nxt = 1'b1;
        l_nxt      = '0;
        rend_nxt   = count_r;
        sp_nxt     = '0;
      end
      ST_RD_L: begin
        mem_raddr = l_r[IDX_W-1:0];
      end
      ST_CHK_L: begin
        if (key_low) l_nxt = l_r + CNT_W'(1);
        else lkey_nxt = mem_rdata_r;
      end
      ST_RD_R: begin
        mem_raddr = IDX_W'(rend_r - CNT_W'(1));
      end
      ST_CHK_R: begin
        if (key_low) begin
          mem_we    = 1'b1;
          mem_waddr = l_r[IDX_W-1:0];
          mem_wdata = mem_rdata_r;
        end else begin
          rend_nxt = rend_r - CNT_W'(1);
        end
      end
      ST_SWAP: begin
        mem_we    = 1'b1;
        mem_waddr = IDX_W'(rend_r - CNT_W'(1));
        mem_wdata = lkey_r;
        l_nxt     = l_r + CNT_W'(1);
        rend_nxt  = rend_r - CNT_W'(1);
      end
      ST_PUSH_HI: begin
        // upper part: split .. right
        stk_wleft  = l_r[IDX_W-1:0];
        stk_wright = right_r;
        stk_wdir   = is_top_r ? 1'b1 : dir_r;
        if (push_ok && (CNT_W'(right_r) > l_r)) begin
          stk_we = 1'b1;
          sp_nxt = sp_r + SP_W'(1);
        end
      end
      ST_PUSH_LO: begin
        // lower part: left .. split-1
        stk_wleft  = left_r;
        stk_wright = IDX_W'(l_r - CNT_W'(1));
        stk_wdir   = is_top_r ? 1'b0 : dir_r;
        if (push_ok && (l_r > CNT_W'(left_r) + CNT_W'(1))) begin
          stk_we = 1'b1;
          sp_nxt = sp_r + SP_W'(1);
        end
      end
      ST_POP: begin
        // top entry is read into the stack read register this cycle
        if (sp_r == '0) begin
          l_nxt = '0;
        end else begin
          sp_nxt = sp_r - SP_W'(1);
        end
      end
      ST_LOAD: begin
        left_nxt   = stk_rd_left_r;
        right_nxt  = stk_rd_right_r;
        bitn_nxt   = stk_rd_bitn_r;
        dir_nxt    = stk_rd_dir_r;
        is_top_nxt = 1'b0;
        l_nxt      = CNT_W'(stk_rd_left_r);
        rend_nxt   = CNT_W'(stk_rd_right_r) + CNT_W'(1);
      end
      ST_EMIT: begin
        mem_raddr     = l_r[IDX_W-1:0];
        emit_v_nxt    = 1'b1;
        emit_last_nxt = (l_r + CNT_W'(1) == count_r);
        emit_ovf_nxt  = ovf_r;
        l_nxt         = l_r + CNT_W'(1);
        if (l_r + CNT_W'(1) == count_r) begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
        end
      end
      default: begin
        emit_v_nxt = 1'b0;
      end
    endcase

    // a single key needs no sort
    if (state_r == ST_START && count_r <= CNT_W'(1)) l_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      asc_r       <= 1'b1;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      sp_r        <= '0;
      emit_v_r    <= 1'b0;
      emit_last_r <= 1'b0;
      emit_ovf_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      asc_r       <= asc_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      sp_r        <= sp_nxt;
      emit_v_r    <= emit_v_nxt;
      emit_last_r <= emit_last_nxt;
      emit_ovf_r  <= emit_ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r   <= left_nxt;
    right_r  <= right_nxt;
    bitn_r   <= bitn_nxt;
    dir_r    <= dir_nxt;
    is_top_r <= is_top_nxt;
    l_r      <= l_nxt;
    rend_r   <= rend_nxt;
    lkey_r   <= lkey_nxt;
  end

  // key store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) key_mem[mem_waddr] <= mem_wdata;
    mem_rdata_r <= key_mem[mem_raddr];
  end

  // range stack: push port and a registered read of the top entry
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_left[sp_r[STK_IDX_W-1:0]]  <= stk_wleft;
      stk_right[sp_r[STK_IDX_W-1:0]] <= stk_wright;
      stk_bitn[sp_r[STK_IDX_W-1:0]]  <= stk_wbitn;
      stk_dir[sp_r[STK_IDX_W-1:0]]   <= stk_wdir;
    end
    stk_rd_left_r  <= stk_left[stk_top];
    stk_rd_right_r <= stk_right[stk_top];
    stk_rd_bitn_r  <= stk_bitn[stk_top];
    stk_rd_dir_r   <= stk_dir[stk_top];
  end

endmodule
